### hw/rtl/peer_table_age_evict_core_defines.svh
// Assertion macros for the peer table core.
`ifndef PEER_TABLE_AGE_EVICT_CORE_DEFINES_SVH
`define PEER_TABLE_AGE_EVICT_CORE_DEFINES_SVH
// Assert that a condition implies a consequence in the same cycle.
`define PTAE_ASSERT_IMP(lbl, clk, rstn, cond, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (cond) |-> (cons)) \
        else $error("assertion failed");
// Assert that a condition implies a consequence in the following cycle.
`define PTAE_ASSERT_NXT(lbl, clk, rstn, cond, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (cond) |=> (cons)) \
        else $error("assertion failed");
`endif

### hw/rtl/ptae_pkg.sv
// Shared types, constants and codes for the peer table core.
package ptae_pkg;
    localparam int TABLE_SLOTS = 32;
    localparam int SLOT_W = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
    localparam int CNT_W = $clog2(TABLE_SLOTS + 1);

    localparam logic [1:0] ACT_ADD = 2'd0;
    localparam logic [1:0] ACT_REMOVE = 2'd1;
    localparam logic [1:0] ACT_LOOKUP = 2'd2;
    localparam logic [1:0] ACT_RSVD = 2'd3;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_NO_PEER = 2'd1;
    localparam logic [1:0] ST_INVALID = 2'd2;

    typedef enum logic [1:0] {
        FSM_IDLE,
        FSM_SCAN,
        FSM_APPLY,
        FSM_OUT
    } fsm_t;

    // Key of one entry.
    typedef struct packed {
        logic        family;
        logic [63:0] addr_high;
        logic [63:0] addr_low;
        logic [15:0] port;
    } key_t;

    // Search token that travels down the chain, one cell per cycle.
    typedef struct packed {
        logic              hit;
        logic [SLOT_W-1:0] hit_slot;
        logic              have_free;
        logic [SLOT_W-1:0] free_slot;
        logic [31:0]       best_age;
        logic [SLOT_W-1:0] best_slot;
    } scan_t;

    // Write command broadcast to all cells.
    typedef struct packed {
        logic              wr;
        logic              clr;
        logic              touch;
        logic [SLOT_W-1:0] slot;
    } cmd_t;
endpackage

### hw/rtl/ptae_cell.sv
// One table slot: holds an entry and folds it into the passing search token.
module ptae_cell (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic [ptae_pkg::SLOT_W-1:0] idx,
    input  logic                        in_range,
    input  ptae_pkg::key_t              key,
    input  logic [31:0]                 now_tick,
    input  ptae_pkg::cmd_t              cmd,
    input  ptae_pkg::scan_t             scan_in,
    output ptae_pkg::scan_t             scan_out
);
    logic           active_reg;
    ptae_pkg::key_t key_reg;
    logic [31:0]    seen_reg;
    logic [31:0]    age;
    logic           sel;

    assign sel = cmd.slot == idx;
    assign age = now_tick - seen_reg;

    // Update the entry on a write, clear or touch aimed at this slot.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= 1'b0;
            key_reg    <= '0;
            seen_reg   <= '0;
        end else if (sel) begin
            if (cmd.clr) begin
                active_reg <= 1'b0;
                key_reg    <= '0;
                seen_reg   <= '0;
            end else if (cmd.wr) begin
                active_reg <= 1'b1;
                key_reg    <= key;
                seen_reg   <= now_tick;
            end else if (cmd.touch) begin
                seen_reg <= now_tick;
            end
        end
    end

    // Fold match, first free and oldest age into the token.
    always_comb begin
        scan_out = scan_in;
        if (in_range) begin
            if (!scan_in.hit && active_reg && key_reg == key) begin
                scan_out.hit      = 1'b1;
                scan_out.hit_slot = idx;
            end
            if (!scan_in.have_free && !active_reg) begin
                scan_out.have_free = 1'b1;
                scan_out.free_slot = idx;
            end
            if (age > scan_in.best_age) begin
                scan_out.best_age  = age;
                scan_out.best_slot = idx;
            end
        end
    end
endmodule

### hw/rtl/ptae_chain.sv
// Row of cells; the search token advances one cell per cycle.
module ptae_chain (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [ptae_pkg::CNT_W-1:0]  n_slots,
    input  ptae_pkg::key_t              key,
    input  logic [31:0]                 now_tick,
    input  ptae_pkg::cmd_t              cmd,
    output ptae_pkg::scan_t             result,
    output logic                        done
);
    localparam int N = ptae_pkg::TABLE_SLOTS;
    ptae_pkg::scan_t scan_reg [N];
    ptae_pkg::scan_t scan_next [N];
    logic [N-1:0]    vld_reg;
    ptae_pkg::scan_t seed;

    always_comb begin
        seed = '0;
    end

    for (genvar i = 0; i < N; i++) begin : g_cell
        ptae_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .idx      (ptae_pkg::SLOT_W'(i)),
            .in_range (ptae_pkg::CNT_W'(i) < n_slots),
            .key      (key),
            .now_tick (now_tick),
            .cmd      (cmd),
            .scan_in  ((i == 0) ? seed : scan_reg[(i == 0) ? 0 : i-1]),
            .scan_out (scan_next[i])
        );
    end

    // Advance the token and its valid mark between cells.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= {vld_reg[N-2:0], start};
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < N; i++) begin
            scan_reg[i] <= scan_next[i];
        end
    end

    assign result = scan_reg[N-1];
    assign done = vld_reg[N-1];
endmodule

### hw/rtl/peer_table_age_evict_core.sv
// Top level of the peer table core: handshakes, control sequencer and result register.
//  channel  | direction | contents
//  s_       | in        | tdata: action, family, addr_high, addr_low, peer_port, now_tick
//  m_       | out       | tdata: status, found, slot, evicted, active_peers
//  cfg_     | in        | slots_in_use write
// Each word passes through the control states in order: SCAN launches the search,
// the token walks the row of cells one slot per cycle while APPLY waits for it,
// OUT applies the update and loads the result once the output register is free,
// and IDLE takes the next word.
// Reset (aresetn low, synchronous) clears all entries and the count at once.
// A new word is taken once the previous result has moved into the output register;
// a stalled result holds while the next word searches.
`include "peer_table_age_evict_core_defines.svh"
module peer_table_age_evict_core (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // [1:0] action, [2] family, [66:3] addr_high, [130:67] addr_low,
    // [146:131] peer_port, [178:147] now_tick, [183:179] zero
    input  logic [183:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // [1:0] status, [2] found, [7:3] slot, [8] evicted, [14:9] active_peers, [15] zero
    output logic [15:0]  m_tdata,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [5:0]   cfg_data
);
    localparam int SW = ptae_pkg::SLOT_W;
    localparam int CW = ptae_pkg::CNT_W;

    ptae_pkg::fsm_t  state_reg, state_next;
    logic [5:0]      cfg_reg;
    logic [1:0]      act_reg;
    ptae_pkg::key_t  key_reg;
    logic [31:0]     now_reg;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic [CW-1:0]   n_slots;
    logic            start;
    ptae_pkg::cmd_t  cmd;
    ptae_pkg::scan_t res;
    logic            done;
    logic            m_valid_reg;
    logic [15:0]     m_data_reg;
    logic [1:0]      st;
    logic            fnd, evc, ld_out;
    logic [SW-1:0]   slt;
    logic            s_acc;

    assign cfg_ready = 1'b1;
    assign s_tready = state_reg == ptae_pkg::FSM_IDLE;
    assign s_acc = s_tvalid && s_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata = m_data_reg;

    // Clamp the slot count into one to TABLE_SLOTS.
    always_comb begin
        if (cfg_reg == 6'd0) begin
            n_slots = CW'(1);
        end else if ({1'b0, cfg_reg} > 7'(ptae_pkg::TABLE_SLOTS)) begin
            n_slots = CW'(ptae_pkg::TABLE_SLOTS);
        end else begin
            n_slots = CW'(cfg_reg);
        end
    end

    ptae_chain u_chain (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (start),
        .n_slots  (n_slots),
        .key      (key_reg),
        .now_tick (now_reg),
        .cmd      (cmd),
        .result   (res),
        .done     (done)
    );

    // Hold the register and the captured word.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= 6'd32;
        end else if (cfg_valid && cfg_ready) begin
            cfg_reg <= cfg_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_acc) begin
            act_reg           <= s_tdata[1:0];
            key_reg.family    <= s_tdata[2];
            key_reg.addr_high <= s_tdata[2] ? s_tdata[66:3] : 64'd0;
            key_reg.addr_low  <= s_tdata[2] ? s_tdata[130:67] : {32'd0, s_tdata[98:67]};
            key_reg.port      <= s_tdata[146:131];
            now_reg           <= s_tdata[178:147];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ptae_pkg::FSM_IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            if (ld_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ld_out) begin
            m_data_reg <= {1'b0, 6'(cnt_next), evc, 5'(slt), fnd, st};
        end
    end

    // Sequence search, update and result delivery.
    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        start      = 1'b0;
        cmd        = '0;
        st         = ptae_pkg::ST_INVALID;
        fnd        = 1'b0;
        evc        = 1'b0;
        slt        = '0;
        ld_out     = 1'b0;
        unique case (state_reg)
            ptae_pkg::FSM_IDLE: begin
                if (s_acc) begin
                    state_next = ptae_pkg::FSM_SCAN;
                end
            end
            ptae_pkg::FSM_SCAN: begin
                start      = 1'b1;
                state_next = ptae_pkg::FSM_APPLY;
            end
            ptae_pkg::FSM_APPLY: begin
                if (done) begin
                    state_next = ptae_pkg::FSM_OUT;
                end
            end
            ptae_pkg::FSM_OUT: begin
                if (!m_valid_reg || m_tready) begin
                    ld_out     = 1'b1;
                    state_next = ptae_pkg::FSM_IDLE;
                    priority if (act_reg == ptae_pkg::ACT_ADD) begin
                        if (!(key_reg.family && key_reg.port == 16'd0)) begin
                            st = ptae_pkg::ST_OK;
                            if (res.hit) begin
                                fnd       = 1'b1;
                                slt       = res.hit_slot;
                                cmd.touch = 1'b1;
                                cmd.slot  = res.hit_slot;
                            end else begin
                                cmd.wr = 1'b1;
                                if (res.have_free) begin
                                    slt      = res.free_slot;
                                    cnt_next = cnt_reg + CW'(1);
                                end else begin
                                    slt = res.best_slot;
                                    evc = 1'b1;
                                    if (cnt_reg == '0) begin
                                        cnt_next = CW'(1);
                                    end
                                end
                                cmd.slot = slt;
                            end
                        end
                    end else if (act_reg == ptae_pkg::ACT_REMOVE) begin
                        if (!key_reg.family) begin
                            if (res.hit) begin
                                st       = ptae_pkg::ST_OK;
                                fnd      = 1'b1;
                                slt      = res.hit_slot;
                                cmd.clr  = 1'b1;
                                cmd.slot = res.hit_slot;
                                if (cnt_reg != '0) begin
                                    cnt_next = cnt_reg - CW'(1);
                                end
                            end else begin
                                st = ptae_pkg::ST_NO_PEER;
                            end
                        end
                    end else if (act_reg == ptae_pkg::ACT_LOOKUP) begin
                        if (res.hit) begin
                            st  = ptae_pkg::ST_OK;
                            fnd = 1'b1;
                            slt = res.hit_slot;
                        end else begin
                            st = ptae_pkg::ST_NO_PEER;
                        end
                    end
                end
            end
            default: state_next = ptae_pkg::FSM_IDLE;
        endcase
    end

    `PTAE_ASSERT_IMP(a_no_take_busy, aclk, aresetn, state_reg != ptae_pkg::FSM_IDLE, !s_tready)
    `PTAE_ASSERT_NXT(a_out_valid, aclk, aresetn, ld_out, m_tvalid)
    `PTAE_ASSERT_IMP(a_one_cmd, aclk, aresetn, 1'b1, $onehot0({cmd.wr, cmd.clr, cmd.touch}))
endmodule
